FILE: hw/rtl/ddti_pkg.sv
// Shared types and constants for the disparity-to-depth table block.
package ddti_pkg;

  localparam int MAX_ENTRIES_DEF = 2048;

  localparam int DISP_W  = 16;
  localparam int DEPTH_W = 16;
  localparam int BYTE_W  = 8;
  localparam int FRAC_W  = 4;
  localparam int IDX_W   = 13;

  localparam logic [DISP_W:0] HALF_STEP = (DISP_W + 1)'(8);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LOAD   = 1'b1
  } ddti_op_t;

  typedef struct packed {
    logic accept_load;
    logic accept_lookup;
    logic issue_read;
    logic do_mul;
    logic load_out;
  } ddti_cmd_t;

endpackage

FILE: hw/rtl/ddti_ctrl.sv
// Controller state machine: sequences one lookup and owns the output valid flag.
module ddti_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               opcode,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output ddti_pkg::ddti_cmd_t cmd
);
  import ddti_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd               = '0;
    cmd.accept_load   = accept && (opcode == OP_LOAD);
    cmd.accept_lookup = accept && (opcode == OP_LOOKUP);
    cmd.issue_read    = (state == ST_READ);
    cmd.do_mul        = (state == ST_MUL);
    cmd.load_out      = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Hold the finished word until taken; a new result refills at once.
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.accept_lookup) state <= ST_READ;
        end
        ST_READ:   state <= ST_MUL;
        ST_MUL:    state <= ST_FINISH;
        ST_FINISH: begin
          if (cmd.load_out) state <= ST_IDLE;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ddti_dp.sv
// Datapath: table memory, load counter, index clamp, interpolation and result register.
module ddti_dp #(
  parameter int MAX_ENTRIES = ddti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ddti_pkg::ddti_cmd_t            cmd,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic [ddti_pkg::BYTE_W-1:0]    table_byte,
  input  logic                           first_byte,
  input  logic [ddti_pkg::DISP_W-1:0]    disparity_q4,
  output logic [ddti_pkg::DEPTH_W-1:0]   depth_mm,
  output logic                           table_ok
);
  import ddti_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(2 * MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(2 * MAX_ENTRIES);
  localparam int PW = DEPTH_W + 1 + FRAC_W + 1;

  logic [DEPTH_W-1:0] mem [MAX_ENTRIES];

  logic               round_nearest;
  logic [CW-1:0]      byte_count;
  logic [BYTE_W-1:0]  high_byte_latch;
  logic               load_overflow;

  logic [DISP_W-1:0]  d_q;
  logic               valid_q;
  logic               rn_q;
  logic [DEPTH_W-1:0] rd_a;
  logic [DEPTH_W-1:0] rd_b;
  logic               pass_q;
  logic signed [PW-1:0] prod_q;

  // Load path
  logic [CW-1:0] cnt_eff;
  logic          ovf_eff;
  logic [CW-1:0] byte_count_next;
  logic          load_overflow_next;
  logic          wr_en;
  logic          latch_en;
  logic [AW-1:0] wr_addr;
  logic          table_valid;

  always_comb begin
    cnt_eff            = first_byte ? '0 : byte_count;
    ovf_eff            = first_byte ? 1'b0 : load_overflow;
    byte_count_next    = cnt_eff;
    load_overflow_next = ovf_eff;
    wr_en              = 1'b0;
    latch_en           = 1'b0;
    priority if (ovf_eff) begin
      load_overflow_next = 1'b1;
    end else if (cnt_eff == FULL) begin
      load_overflow_next = 1'b1;
    end else begin
      latch_en        = !cnt_eff[0];
      wr_en           = cnt_eff[0];
      byte_count_next = cnt_eff + 1'b1;
    end
    wr_addr = cnt_eff[AW:1];
  end

  assign table_valid = !load_overflow && (byte_count >= CW'(2)) && !byte_count[0] &&
                       (byte_count <= FULL);

  // Read address selection
  logic [CW-2:0]   n_ent;
  logic [CW-2:0]   last_w;
  logic [IDX_W-1:0] last_i;
  logic [IDX_W-1:0] idx_f;
  logic [DISP_W:0]  near_sum;
  logic [IDX_W-1:0] idx_n;
  logic [IDX_W-1:0] clamp_n;
  logic             past;
  logic [IDX_W-1:0] addr_a_i;
  logic [IDX_W-1:0] addr_b_i;

  always_comb begin
    n_ent    = byte_count[CW-1:1];
    last_w   = n_ent - 1'b1;
    last_i   = IDX_W'(last_w[AW-1:0]);
    idx_f    = IDX_W'(d_q[DISP_W-1:FRAC_W]);
    near_sum = {1'b0, d_q} + HALF_STEP;
    idx_n    = IDX_W'(near_sum[DISP_W:FRAC_W]);
    clamp_n  = (idx_n > last_i) ? last_i : idx_n;
    past     = (idx_f >= last_i);
    addr_a_i = rn_q ? clamp_n : (past ? last_i : idx_f);
    addr_b_i = idx_f + 1'b1;
  end

  // Interpolation arithmetic
  logic signed [DEPTH_W:0]  diff;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PW-1:0]     step;
  logic signed [PW-1:0]     interp_sum;
  logic [DEPTH_W-1:0]       result;

  always_comb begin
    diff       = signed'({1'b0, rd_b}) - signed'({1'b0, rd_a});
    frac_s     = signed'({1'b0, d_q[FRAC_W-1:0]});
    step       = prod_q >>> FRAC_W;
    interp_sum = signed'(PW'(rd_a)) + step;
    result     = pass_q ? rd_a : interp_sum[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_nearest   <= 1'b0;
      byte_count      <= '0;
      high_byte_latch <= '0;
      load_overflow   <= 1'b0;
    end else begin
      if (cfg_wr_en) round_nearest <= cfg_wr_data;
      if (cmd.accept_load) begin
        byte_count    <= byte_count_next;
        load_overflow <= load_overflow_next;
        if (latch_en) high_byte_latch <= table_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_load && wr_en) begin
      mem[wr_addr] <= {high_byte_latch, table_byte};
    end
    if (cmd.issue_read) begin
      rd_a   <= mem[addr_a_i[AW-1:0]];
      rd_b   <= mem[addr_b_i[AW-1:0]];
      pass_q <= rn_q || past;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_lookup) begin
      d_q     <= disparity_q4;
      valid_q <= table_valid;
      rn_q    <= round_nearest;
    end
    if (cmd.do_mul) begin
      prod_q <= PW'(diff) * PW'(frac_s);
    end
    if (cmd.load_out) begin
      depth_mm <= (valid_q && (d_q != '0)) ? result : '0;
      table_ok <= valid_q;
    end
  end

endmodule

FILE: hw/rtl/disparity_depth_table_interp.sv
// Top level of the disparity-to-depth table lookup block.
// Converts a Q4 disparity into depth in millimeters through a table that is
// loaded one byte at a time over the same input channel (opcode 1 = load byte,
// big-endian pairs form 16-bit entries; first_byte restarts the load). The
// table answers only while it holds an even, nonzero number of bytes and has
// not overflowed past 2*MAX_ENTRIES bytes; otherwise a lookup returns depth 0
// with table_ok 0, and a disparity of 0 always returns depth 0. round_nearest
// (written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce) picks the
// nearest entry, else floor-linear interpolation between neighbors. A load
// word leaves the block idle and yields no output word. A lookup word holds
// the block through capture, registered two-port table read, multiply and
// result register before the next word is taken; the result waits in an
// output register, so load words are still taken while it is not yet read.
module disparity_depth_table_interp #(
  parameter int MAX_ENTRIES = ddti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [ddti_pkg::BYTE_W-1:0]   table_byte,
  input  logic                          first_byte,
  input  logic [ddti_pkg::DISP_W-1:0]   disparity_q4,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ddti_pkg::DEPTH_W-1:0]  depth_mm,
  output logic                          table_ok
);
  import ddti_pkg::*;

  ddti_cmd_t cmd;

  // Sequence lookups and own the output handshake.
  ddti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Table storage, load bookkeeping and the interpolation arithmetic.
  ddti_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .table_byte   (table_byte),
    .first_byte   (first_byte),
    .disparity_q4 (disparity_q4),
    .depth_mm     (depth_mm),
    .table_ok     (table_ok)
  );

  // An invalid table never yields a nonzero depth.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_ok |-> depth_mm == '0)
    else $error("nonzero depth reported with invalid table");

  // A lookup word occupies the block: no word is taken in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_LOOKUP) |=> !in_ready)
    else $error("input taken right after a lookup");

  // A load word never produces a result word.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result appeared after a load word");

endmodule

FILE: sim/depth_lookup_monitor.sv
// Monitor that predicts and checks every result word of the depth table block.
module depth_lookup_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         opcode,
  input  logic [ddti_pkg::BYTE_W-1:0]  table_byte,
  input  logic                         first_byte,
  input  logic [ddti_pkg::DISP_W-1:0]  disparity_q4,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [ddti_pkg::DEPTH_W-1:0] depth_mm,
  input  logic                         table_ok,
  output int                           outstanding,
  output int                           mismatches,
  output int                           words_checked
);
  import ddti_pkg::*;

  localparam int TABLE_BYTES = 2 * MAX_ENTRIES_DEF;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    logic [DISP_W-1:0]  disp;
    logic [DEPTH_W-1:0] depth;
    logic               ok;
  } depth_word_t;

  logic [DEPTH_W-1:0] depth_tab [MAX_ENTRIES_DEF];
  int unsigned        byte_cnt;
  logic [BYTE_W-1:0]  high_byte;
  logic               load_ovf;
  logic               nearest_mode;
  depth_word_t        depth_words_q [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic take_table_byte(input logic [BYTE_W-1:0] b, input logic restart);
    if (restart) begin
      byte_cnt = 0;
      load_ovf = 1'b0;
    end
    if (load_ovf) return;
    if (byte_cnt >= TABLE_BYTES) begin
      load_ovf = 1'b1;
      return;
    end
    if (!byte_cnt[0]) begin
      high_byte = b;
    end else begin
      depth_tab[byte_cnt >> 1] = {high_byte, b};
    end
    byte_cnt++;
  endtask

  function automatic logic [DEPTH_W-1:0] depth_at(input logic [DISP_W-1:0] disp,
                                                  input int unsigned entry_cnt);
    int unsigned idx;
    int          a;
    int          b;
    int          prod;
    logic [31:0] sum;
    if (nearest_mode) begin
      idx = (32'(disp) + 32'(HALF_STEP)) >> FRAC_W;
      if (idx > entry_cnt - 1) idx = entry_cnt - 1;
      return depth_tab[idx];
    end
    idx = 32'(disp) >> FRAC_W;
    if (idx >= entry_cnt - 1) return depth_tab[entry_cnt - 1];
    a    = int'(depth_tab[idx]);
    b    = int'(depth_tab[idx + 1]);
    prod = (b - a) * int'(disp[FRAC_W-1:0]);
    // arithmetic shift of a signed product rounds toward minus infinity
    sum  = a + (prod >>> FRAC_W);
    return sum[DEPTH_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    depth_word_t want;
    logic        ok;
    if (rst) begin
      byte_cnt      = 0;
      high_byte     = '0;
      load_ovf      = 1'b0;
      nearest_mode  = 1'b0;
      mismatches    = 0;
      words_checked = 0;
      depth_words_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (depth_words_q.size() == 0) begin
          report_mismatch($sformatf("result word with none pending: depth %0d ok %0b",
                                    depth_mm, table_ok));
        end else begin
          want = depth_words_q.pop_front();
          words_checked++;
          if (depth_mm !== want.depth)
            report_mismatch($sformatf("disparity %h: depth_mm %h, predicted %h",
                                      want.disp, depth_mm, want.depth));
          if (table_ok !== want.ok)
            report_mismatch($sformatf("disparity %h: table_ok %b, predicted %b",
                                      want.disp, table_ok, want.ok));
        end
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_LOAD) begin
          take_table_byte(table_byte, first_byte);
        end else begin
          ok = !load_ovf && byte_cnt >= 2 && !byte_cnt[0] && byte_cnt <= TABLE_BYTES;
          want.disp  = disparity_q4;
          want.ok    = ok;
          want.depth = (ok && disparity_q4 != '0) ? depth_at(disparity_q4, byte_cnt >> 1)
                                                  : '0;
          depth_words_q.push_back(want);
        end
      end
      if (cfg_wr_en) nearest_mode = cfg_wr_data;
    end
    outstanding <= depth_words_q.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the simulation: drives the depth table block and reports the verdict.
module testbench;
  import ddti_pkg::*;

  localparam int TABLE_BYTES = 2 * MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;     // cycles the output side stays blocked
  localparam int IDLE_PAUSE  = 8;       // idle wait that covers the lookup path
  localparam int BURST_WORDS = 75;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic                 cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 opcode;
  logic [BYTE_W-1:0]    table_byte;
  logic                 first_byte;
  logic [DISP_W-1:0]    disparity_q4;
  logic                 out_valid;
  logic                 out_ready;
  logic [DEPTH_W-1:0]   depth_mm;
  logic                 table_ok;

  int                   outstanding;
  int                   mismatches;
  int                   words_checked;

  int                   tx_idle_pct;
  int                   rx_idle_pct;
  logic                 rx_hold_req = 1'b0;
  int                   cycle_cnt = 0;
  int                   loads_sent = 0;
  int                   lookups_sent = 0;
  int unsigned          bytes_now = 0;  // bytes in the current load, as driven

  always #5 clk = ~clk;

  disparity_depth_table_interp #(
    .MAX_ENTRIES (MAX_ENTRIES_DEF)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .table_byte   (table_byte),
    .first_byte   (first_byte),
    .disparity_q4 (disparity_q4),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .depth_mm     (depth_mm),
    .table_ok     (table_ok)
  );

  depth_lookup_monitor i_monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .table_byte    (table_byte),
    .first_byte    (first_byte),
    .disparity_q4  (disparity_q4),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .depth_mm      (depth_mm),
    .table_ok      (table_ok),
    .outstanding   (outstanding),
    .mismatches    (mismatches),
    .words_checked (words_checked)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random backpressure, plus one long hold on request so the
  // result register fills and the block has to stall its input.
  initial begin : rx_side
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        held = 0;
        while (held < LONG_HOLD) begin
          out_ready <= 1'b0;
          @(posedge clk);
          held++;
        end
        rx_hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one word, idling first at random, and hold it until accepted.
  task automatic send_word(input ddti_op_t op, input logic [BYTE_W-1:0] tbyte,
                           input logic first, input logic [DISP_W-1:0] disp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    table_byte   <= tbyte;
    first_byte   <= first;
    disparity_q4 <= disp;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op == OP_LOAD) loads_sent++;
    else lookups_sent++;
  endtask

  // Load word; the disparity field is noise the block must ignore.
  task automatic send_load(input logic [BYTE_W-1:0] tbyte, input logic restart);
    logic [DISP_W-1:0] junk;
    junk = DISP_W'($urandom);
    if (restart) bytes_now = 0;
    bytes_now++;
    send_word(OP_LOAD, tbyte, restart, junk);
  endtask

  // Lookup word; table_byte and first_byte carry noise.
  task automatic send_lookup(input logic [DISP_W-1:0] disp);
    logic [BYTE_W-1:0] junk;
    junk = BYTE_W'($urandom);
    send_word(OP_LOOKUP, junk, 1'($urandom_range(1)), disp);
  endtask

  // Restart the load and stream n_bytes random table bytes.
  task automatic load_table(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_load(BYTE_W'($urandom_range(255)), i == 0);
  endtask

  // Mostly land inside or just past the loaded table; some holes and some
  // full-range disparities.
  function automatic logic [DISP_W-1:0] pick_disp();
    int unsigned       span;
    logic [DISP_W-1:0] d;
    span = (bytes_now / 2) * 16 + 32;
    if (span > 65535) span = 65535;
    case ($urandom_range(9))
      0:       d = '0;
      1, 2:    d = DISP_W'($urandom);
      default: d = DISP_W'($urandom_range(span));
    endcase
    return d;
  endfunction

  // Drain, let the pipeline settle, then write the mode register.
  task automatic set_lookup_mode(input logic nearest);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= nearest;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic: mostly a fresh table followed by lookups into it, the rest
  // stray lookups, loads that extend without restart, and odd-length loads.
  task automatic random_burst(input int n_words);
    int start;
    int pick;
    int k;
    start = loads_sent + lookups_sent;
    while (loads_sent + lookups_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        k = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
        load_table(2 * k);
        repeat ($urandom_range(2, 8)) send_lookup(pick_disp());
      end else if (pick < 80) begin
        send_lookup(pick_disp());
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_load(BYTE_W'($urandom_range(255)), 1'b0);
        send_lookup(pick_disp());
      end else begin
        load_table(2 * $urandom_range(0, 10) + 1);
        send_lookup(pick_disp());
      end
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    opcode       = OP_LOOKUP;
    table_byte   = '0;
    first_byte   = 1'b0;
    disparity_q4 = '0;
    tx_idle_pct  = 9;
    rx_idle_pct  = 46;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_lookup_mode(1'b0);

    // Nothing loaded yet: the table reads as invalid.
    send_lookup(16'h1234);
    // Start loading without a restart; an odd byte count is still invalid.
    send_load(8'hAB, 1'b0);
    send_lookup(16'h0010);
    send_load(8'hCD, 1'b0);
    // Single-entry table: hole, fraction only, far past the end.
    send_lookup(16'h0000);
    send_lookup(16'h0001);
    send_lookup(16'hFFFF);

    // Restart with extreme entries 0x0000, 0xFFFF, 0x0000 for steep slopes.
    send_load(8'h00, 1'b1);
    send_load(8'h00, 1'b0);
    send_load(8'hFF, 1'b0);
    send_load(8'hFF, 1'b0);
    send_load(8'h00, 1'b0);
    send_load(8'h00, 1'b0);
    send_lookup(16'h000F);  // rising slope, top fraction
    send_lookup(16'h001F);  // falling slope, negative product floors down
    send_lookup(16'h0018);
    send_lookup(16'h0020);  // exactly on the last entry
    send_lookup(16'h0021);  // past the end

    // Same table, nearest entry: rounding edges and the clamp.
    set_lookup_mode(1'b1);
    send_lookup(16'h0007);
    send_lookup(16'h0008);
    send_lookup(16'h0017);
    send_lookup(16'h0028);
    send_lookup(16'hFFFF);
    send_lookup(16'h0000);

    // Fill the table to capacity and probe its last entries in both modes.
    set_lookup_mode(1'b0);
    load_table(TABLE_BYTES);
    send_lookup(16'hFFFF);
    send_lookup(DISP_W'((MAX_ENTRIES_DEF - 2) * 16 + 15));
    send_lookup(DISP_W'((MAX_ENTRIES_DEF - 1) * 16));
    set_lookup_mode(1'b1);
    send_lookup(16'hFFFF);
    send_lookup(DISP_W'((MAX_ENTRIES_DEF - 1) * 16 - 9));
    send_lookup(DISP_W'((MAX_ENTRIES_DEF - 1) * 16 + 7));

    // One byte too many: overflow sticks, later bytes drop until a restart.
    send_load(8'h5A, 1'b0);
    send_lookup(16'h0100);
    send_load(8'hA5, 1'b0);
    send_lookup(16'h0000);
    send_load(8'h11, 1'b1);
    send_lookup(16'h0008);

    // Three flow-control mixes, each run in both lookup modes.
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 9 : (p == 1) ? 46 : 0;
      rx_idle_pct = (p == 0) ? 46 : (p == 1) ? 9 : 0;
      set_lookup_mode(1'b1);
      if (p == 2) begin
        // Block the output and keep pushing lookups until the input stalls.
        rx_hold_req = 1'b1;
        repeat (12) send_lookup(pick_disp());
      end
      random_burst(BURST_WORDS);
      set_lookup_mode(1'b0);
      random_burst(BURST_WORDS);
    end

    // Drop valid, drain every pending result, then allow for stragglers.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("tb: drove %0d load words and %0d lookup words, checked %0d results",
             loads_sent, lookups_sent, words_checked);
    $display("tb: covered both lookup modes, a full table with overflow, three %s",
             "backpressure mixes and a long output hold");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
